// File: sv/mlfd_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the marker/length frame deframer
// no dependencies

package mlfd_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // register indexes
  localparam logic REG_BEGIN_MARKER = 1'b0;
  localparam logic REG_END_MARKER   = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_FINISHED = 2'd1;
  localparam logic [1:0] KIND_ERROR    = 2'd2;
  localparam logic [1:0] KIND_NONE     = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_BAD_BEGIN = 2'd1;
  localparam logic [1:0] ERR_BAD_END   = 2'd2;
  localparam logic [1:0] ERR_TRUNCATED = 2'd3;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  out_byte;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
    logic [1:0]  error_code;
    logic        buffer_done;
  } result_t;

  typedef struct packed {
    logic [15:0] begin_marker;
    logic [15:0] end_marker;
  } markers_t;

endpackage

// File: sv/mlfd_in_if.sv
`timescale 1ns / 1ps
// byte stream channel into the deframer
// no dependencies

interface mlfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       buffer_last;

  modport source (output valid, output in_byte, output buffer_last, input ready);
  modport sink (input valid, input in_byte, input buffer_last, output ready);
endinterface

// File: sv/mlfd_out_if.sv
`timescale 1ns / 1ps
// result channel out of the deframer
// no dependencies

interface mlfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  out_byte;
  logic [7:0]  frame_type;
  logic [15:0] frame_length;
  logic [1:0]  error_code;
  logic        buffer_done;

  modport source (
    output valid, output result_kind, output out_byte, output frame_type,
    output frame_length, output error_code, output buffer_done, input ready
  );
  modport sink (
    input valid, input result_kind, input out_byte, input frame_type,
    input frame_length, input error_code, input buffer_done, output ready
  );
endinterface

// File: sv/mlfd_cfg_regs.sv
`timescale 1ns / 1ps
// apb register file holding the begin and end marker words
// depends on mlfd_pkg

module mlfd_cfg_regs
  import mlfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output markers_t              markers
);

  logic reg_sel;
  logic wr_en;

  assign reg_sel = paddr[2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      markers <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_BEGIN_MARKER: markers.begin_marker <= pwdata[15:0];
        REG_END_MARKER:   markers.end_marker   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_BEGIN_MARKER: prdata = {{(CFG_DATA_W-16){1'b0}}, markers.begin_marker};
      REG_END_MARKER:   prdata = {{(CFG_DATA_W-16){1'b0}}, markers.end_marker};
      default:          prdata = '0;
    endcase
  end

endmodule

// File: sv/mlfd_parser.sv
`timescale 1ns / 1ps
// frame parse state machine: one byte per accepted request, at most one result
// depends on mlfd_pkg

module mlfd_parser
  import mlfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       buffer_last,
  input  markers_t   markers,
  output logic       res_valid,
  output result_t    res
);

  localparam logic [2:0] PH_BEGIN_LO = 3'd0;
  localparam logic [2:0] PH_BEGIN_HI = 3'd1;
  localparam logic [2:0] PH_TYPE     = 3'd2;
  localparam logic [2:0] PH_LEN_LO   = 3'd3;
  localparam logic [2:0] PH_LEN_HI   = 3'd4;
  localparam logic [2:0] PH_PAYLOAD  = 3'd5;
  localparam logic [2:0] PH_END      = 3'd6;
  localparam logic [2:0] PH_SKIP     = 3'd7;

  logic [2:0]  phase, phase_next;
  logic [15:0] payload_remaining, payload_remaining_next;
  logic [7:0]  held_type, held_type_next;
  logic [15:0] held_length, held_length_next;
  logic [7:0]  held_low_byte, held_low_byte_next;

  logic [15:0] word;
  logic [15:0] remaining_dec;
  logic [1:0]  kind;
  logic [1:0]  err;
  logic [7:0]  ob;

  assign word          = {in_byte, held_low_byte};
  assign remaining_dec = payload_remaining - 16'd1;

  always_comb begin
    phase_next             = phase;
    payload_remaining_next = payload_remaining;
    held_type_next         = held_type;
    held_length_next       = held_length;
    held_low_byte_next     = held_low_byte;
    kind                   = KIND_NONE;
    err                    = ERR_NONE;
    ob                     = 8'd0;

    unique case (phase)
      PH_BEGIN_LO: begin
        held_low_byte_next = in_byte;
        held_type_next     = 8'd0;
        held_length_next   = 16'd0;
        phase_next         = PH_BEGIN_HI;
      end
      PH_BEGIN_HI: begin
        if (word != markers.begin_marker) begin
          err = ERR_BAD_BEGIN;
        end else begin
          phase_next = PH_TYPE;
        end
      end
      PH_TYPE: begin
        held_type_next = in_byte;
        phase_next     = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        held_low_byte_next = in_byte;
        phase_next         = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        held_length_next       = word;
        payload_remaining_next = word;
        phase_next             = (word == 16'd0) ? PH_END : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        // a payload byte carrying the buffer end becomes a truncation error
        if (!buffer_last) begin
          kind                   = KIND_PAYLOAD;
          ob                     = in_byte;
          payload_remaining_next = remaining_dec;
          if (remaining_dec == 16'd0) begin
            phase_next = PH_END;
          end
        end
      end
      PH_END: begin
        // payload_remaining selects the end marker byte here
        if (payload_remaining == 16'd0) begin
          held_low_byte_next     = in_byte;
          payload_remaining_next = 16'd1;
        end else begin
          payload_remaining_next = 16'd0;
          phase_next             = PH_BEGIN_LO;
          if (word != markers.end_marker) begin
            err = ERR_BAD_END;
          end else begin
            kind = KIND_FINISHED;
          end
        end
      end
      PH_SKIP: begin
      end
      default: begin
      end
    endcase

    if (buffer_last && err == ERR_NONE && kind == KIND_NONE && phase != PH_SKIP) begin
      err = ERR_TRUNCATED;
    end
    if (err != ERR_NONE) begin
      kind       = KIND_ERROR;
      phase_next = PH_SKIP;
    end
    if (buffer_last) begin
      phase_next             = PH_BEGIN_LO;
      payload_remaining_next = 16'd0;
    end
  end

  assign res_valid        = accept && (kind != KIND_NONE);
  assign res.result_kind  = kind;
  assign res.out_byte     = ob;
  assign res.frame_type   = held_type_next;
  assign res.frame_length = held_length_next;
  assign res.error_code   = err;
  assign res.buffer_done  = buffer_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_BEGIN_LO;
      payload_remaining <= 16'd0;
      held_type         <= 8'd0;
      held_length       <= 16'd0;
      held_low_byte     <= 8'd0;
    end else if (accept) begin
      phase             <= phase_next;
      payload_remaining <= payload_remaining_next;
      held_type         <= held_type_next;
      held_length       <= held_length_next;
      held_low_byte     <= held_low_byte_next;
    end
  end

endmodule

// File: sv/mlfd_out_buf.sv
`timescale 1ns / 1ps
// result register with a skid stage so input keeps flowing under output stalls
// depends on mlfd_pkg

module mlfd_out_buf
  import mlfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    can_accept,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    load_out;

  assign can_accept = !skid_valid;
  assign load_out   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_out) begin
      // push cannot happen while the skid stage is full
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// File: sv/marker_length_frame_deframer.sv
`timescale 1ns / 1ps
// Deframer for marker/type/length/payload/marker frames packed into buffers,
// one byte per request, taken every cycle unless input stalls. Any result
// (payload byte, frame finished, or error) is registered in the output
// register, or in the skid if the output stalls. A two-deep output stage
// (result register plus skid) lets input continue while a result waits;
// input stalls only when both are full. APB 0x0/0x4 set begin/end markers.

module marker_length_frame_deframer
  import mlfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  mlfd_in_if.sink               in_stream,
  mlfd_out_if.source            out_result
);

  markers_t markers;
  logic     accept;
  logic     can_accept;
  logic     res_valid;
  result_t  res;
  result_t  out_data;

  mlfd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .markers (markers)
  );

  assign in_stream.ready = can_accept;
  assign accept          = in_stream.valid && can_accept;

  mlfd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_byte     (in_stream.in_byte),
    .buffer_last (in_stream.buffer_last),
    .markers     (markers),
    .res_valid   (res_valid),
    .res         (res)
  );

  mlfd_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_data  (res),
    .can_accept (can_accept),
    .out_valid  (out_result.valid),
    .out_ready  (out_result.ready),
    .out_data   (out_data)
  );

  assign out_result.result_kind  = out_data.result_kind;
  assign out_result.out_byte     = out_data.out_byte;
  assign out_result.frame_type   = out_data.frame_type;
  assign out_result.frame_length = out_data.frame_length;
  assign out_result.error_code   = out_data.error_code;
  assign out_result.buffer_done  = out_data.buffer_done;

endmodule
